>>> rtl/core/dis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dis_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_EXTEND  = 3'd1,
        ST_JOIN    = 3'd2,
        ST_COVERED = 3'd3,
        ST_FULL    = 3'd4,
        ST_LISTED  = 3'd5
    } dis_status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_LIST
    } dis_state_t;

    // table write enables
    typedef struct packed {
        logic wr_start;
        logic wr_end;
    } dis_wr_t;

    localparam int unsigned VAL_W = 31;

endpackage

`default_nettype wire

>>> rtl/core/dis_table.sv
`timescale 1ns / 1ps
`default_nettype none

module dis_table #(
    parameter int unsigned AW = 5
) (
    input  wire logic                       clk,
    input  wire dis_pkg::dis_wr_t           wr,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [dis_pkg::VAL_W-1:0]  wstart,
    input  wire logic [dis_pkg::VAL_W-1:0]  wend,
    input  wire logic [AW-1:0]              raddr,
    output logic      [dis_pkg::VAL_W-1:0]  rstart,
    output logic      [dis_pkg::VAL_W-1:0]  rend
);
    import dis_pkg::*;

    localparam int unsigned DEPTH = 2 ** AW;

    logic [VAL_W-1:0] starts_reg [DEPTH];
    logic [VAL_W-1:0] ends_reg   [DEPTH];
    logic [VAL_W-1:0] rstart_reg;
    logic [VAL_W-1:0] rend_reg;

    // single write port, start and end enabled separately
    always_ff @(posedge clk)
    begin
        if (wr.wr_start)
        begin
            starts_reg[waddr] <= wstart;
        end
        if (wr.wr_end)
        begin
            ends_reg[waddr] <= wend;
        end
    end

    // single registered read port, data appears in the cycle after the address
    always_ff @(posedge clk)
    begin
        rstart_reg <= starts_reg[raddr];
        rend_reg   <= ends_reg[raddr];
    end

    assign rstart = rstart_reg;
    assign rend   = rend_reg;

endmodule

`default_nettype wire

>>> rtl/core/disjoint_interval_set.sv
`timescale 1ns / 1ps
`default_nettype none

// add: the scan state steps past each stored entry below the value, the decide state
//   classifies it, then for an insert or a join a shift state moves the entries
// list: one word per stored interval each cycle (one for an empty table), then back to idle
// decide and list cycles hold while the output word is not taken; one word at a time
// reset (rst_n low, asynchronous) empties the table and drops any pending output word
module disjoint_interval_set #(
    parameter int unsigned MAX_INTERVALS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // value[30:0], zero pad
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // status[2:0], range_start[33:3],
                                            // range_end[64:34], entry_valid[65], zero pad
    output logic             m_axis_tlast   // last_result
);
    import dis_pkg::*;

    localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int unsigned IW = $clog2(MAX_INTERVALS + 1);
    localparam logic [IW-1:0] CNT_MAX = IW'(MAX_INTERVALS);
    localparam logic [IW-1:0] ONE = IW'(1);

    dis_state_t       st_reg, st_next;
    logic [IW-1:0]    ptr_reg, ptr_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] pst_reg, pst_next, pend_reg, pend_next;
    logic [VAL_W-1:0] nst_reg, nst_next, nend_reg, nend_next;

    logic             ovld_reg, ovld_next;
    dis_status_t      ost_reg, ost_next;
    logic [VAL_W-1:0] olo_reg, olo_next, ohi_reg, ohi_next;
    logic             oev_reg, oev_next, olast_reg, olast_next;

    dis_wr_t          wr;
    logic [IW-1:0]    waddr, raddr;
    logic [VAL_W-1:0] wstart, wend, rstart, rend;

    logic             slot_free, has_prev, has_next, cov, left_adj, right_adj;

    dis_table #(.AW(AW)) u_table (
        .clk    (clk),
        .wr     (wr),
        .waddr  (waddr[AW-1:0]),
        .wstart (wstart),
        .wend   (wend),
        .raddr  (raddr[AW-1:0]),
        .rstart (rstart),
        .rend   (rend)
    );

    assign slot_free     = !ovld_reg || m_axis_tready;
    assign s_axis_tready = (st_reg == S_IDLE);
    assign has_prev      = (ptr_reg != '0);
    assign has_next      = (ptr_reg < cnt_reg);
    assign cov           = (has_prev && pend_reg >= val_reg) ||
                           (has_next && nst_reg == val_reg);
    assign left_adj      = has_prev && ({1'b0, pend_reg} + 32'd1 == {1'b0, val_reg});
    assign right_adj     = has_next && ({1'b0, val_reg} + 32'd1 == {1'b0, nst_reg});

    // read address for the next cycle, the table read is registered
    always_comb
    begin
        case (st_next)
            S_SHIFT_DN: raddr = ptr_next + ONE;
            S_SHIFT_UP: raddr = ptr_next - ONE;
            default:    raddr = ptr_next;
        endcase
    end

    // sequencer
    always_comb
    begin
        st_next    = st_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        pst_next   = pst_reg;
        pend_next  = pend_reg;
        nst_next   = nst_reg;
        nend_next  = nend_reg;
        ovld_next  = ovld_reg && !m_axis_tready;
        ost_next   = ost_reg;
        olo_next   = olo_reg;
        ohi_next   = ohi_reg;
        oev_next   = oev_reg;
        olast_next = olast_reg;
        wr         = '0;
        waddr      = ptr_reg;
        wstart     = rstart;
        wend       = rend;

        case (st_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    val_next = s_axis_tdata[VAL_W-1:0];
                    ptr_next = '0;
                    st_next  = s_axis_tuser ? S_LIST : S_SCAN;
                end
            end

            // walk up past entries that start below the value
            S_SCAN:
            begin
                if (ptr_reg < cnt_reg && rstart < val_reg)
                begin
                    pst_next  = rstart;
                    pend_next = rend;
                    ptr_next  = ptr_reg + ONE;
                end
                else
                begin
                    nst_next  = rstart;
                    nend_next = rend;
                    st_next   = S_DECIDE;
                end
            end

            // classify the add and emit its status word
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    ovld_next  = 1'b1;
                    oev_next   = 1'b1;
                    olast_next = 1'b1;
                    idx_next   = ptr_reg;
                    st_next    = S_IDLE;
                    if (cov)
                    begin
                        ost_next = ST_COVERED;
                        olo_next = (has_prev && pend_reg >= val_reg) ? pst_reg : nst_reg;
                        ohi_next = (has_prev && pend_reg >= val_reg) ? pend_reg : nend_reg;
                    end
                    else if (left_adj && right_adj)
                    begin
                        ost_next    = ST_JOIN;
                        olo_next    = pst_reg;
                        ohi_next    = nend_reg;
                        wr.wr_end   = 1'b1;
                        waddr       = ptr_reg - ONE;
                        wend        = nend_reg;
                        st_next     = S_SHIFT_DN;
                    end
                    else if (left_adj)
                    begin
                        ost_next  = ST_EXTEND;
                        olo_next  = pst_reg;
                        ohi_next  = val_reg;
                        wr.wr_end = 1'b1;
                        waddr     = ptr_reg - ONE;
                        wend      = val_reg;
                    end
                    else if (right_adj)
                    begin
                        ost_next    = ST_EXTEND;
                        olo_next    = val_reg;
                        ohi_next    = nend_reg;
                        wr.wr_start = 1'b1;
                        waddr       = ptr_reg;
                        wstart      = val_reg;
                    end
                    else if (cnt_reg == CNT_MAX)
                    begin
                        ost_next = ST_FULL;
                        olo_next = '0;
                        ohi_next = '0;
                        oev_next = 1'b0;
                    end
                    else
                    begin
                        ost_next = ST_NEW;
                        olo_next = val_reg;
                        ohi_next = val_reg;
                        ptr_next = cnt_reg;
                        st_next  = S_SHIFT_UP;
                    end
                end
            end

            // close the gap left by a join
            S_SHIFT_DN:
            begin
                if (ptr_reg + ONE < cnt_reg)
                begin
                    wr       = '{wr_start: 1'b1, wr_end: 1'b1};
                    waddr    = ptr_reg;
                    ptr_next = ptr_reg + ONE;
                end
                else
                begin
                    cnt_next = cnt_reg - ONE;
                    st_next  = S_IDLE;
                end
            end

            // open a slot for a new interval
            S_SHIFT_UP:
            begin
                wr    = '{wr_start: 1'b1, wr_end: 1'b1};
                waddr = ptr_reg;
                if (ptr_reg > idx_reg)
                begin
                    ptr_next = ptr_reg - ONE;
                end
                else
                begin
                    wstart   = val_reg;
                    wend     = val_reg;
                    cnt_next = cnt_reg + ONE;
                    st_next  = S_IDLE;
                end
            end

            // one listed word per cycle while the output slot is free
            S_LIST:
            begin
                if (slot_free)
                begin
                    ovld_next = 1'b1;
                    ost_next  = ST_LISTED;
                    if (cnt_reg == '0)
                    begin
                        olo_next   = '0;
                        ohi_next   = '0;
                        oev_next   = 1'b0;
                        olast_next = 1'b1;
                        st_next    = S_IDLE;
                    end
                    else
                    begin
                        olo_next   = rstart;
                        ohi_next   = rend;
                        oev_next   = 1'b1;
                        olast_next = (ptr_reg + ONE == cnt_reg);
                        ptr_next   = ptr_reg + ONE;
                        if (ptr_reg + ONE == cnt_reg)
                        begin
                            st_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ptr_reg  <= '0;
            cnt_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ptr_reg  <= ptr_next;
            cnt_reg  <= cnt_next;
            ovld_reg <= ovld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        pst_reg   <= pst_next;
        pend_reg  <= pend_next;
        nst_reg   <= nst_next;
        nend_reg  <= nend_next;
        ost_reg   <= ost_next;
        olo_reg   <= olo_next;
        ohi_reg   <= ohi_next;
        oev_reg   <= oev_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {6'd0, oev_reg, ohi_reg, olo_reg, ost_reg};
    assign m_axis_tlast  = olast_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("interval count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + ONE ||
        cnt_reg == $past(cnt_reg) - ONE)
        else $error("interval count jumped");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> ptr_reg <= cnt_reg)
        else $error("table pointer past count");

    a_shift_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SHIFT_UP || st_reg == S_SHIFT_DN) |=> !s_axis_tready || !ovld_next
        || st_reg == S_IDLE)
        else $error("shift overlapped with new item");

endmodule

`default_nettype wire

>>> verif/disjoint_interval_set_test.sv
`timescale 1ns / 1ps

module disjoint_interval_set_test;
    import dis_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_LIST = 1'b1;
    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    typedef struct {
        dis_status_t status;
        logic [30:0] range_start;
        logic [30:0] range_end;
        logic        entry_valid;
        logic        last_result;
    } range_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // value[30:0], zero pad
    logic        s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // status, range_start, range_end, entry_valid, pad
    logic        m_axis_tlast;   // last_result

    // predictor copy of the interval table
    logic [30:0] set_lo [TABLE_DEPTH];
    logic [30:0] set_hi [TABLE_DEPTH];
    int          set_count;

    range_word_t pending_words [$];
    int          error_count;
    int          words_seen;
    int          adds_sent;
    int          lists_sent;
    int          burst_left;
    bit          rx_stall_on;

    disjoint_interval_set DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("timeout with %0d words still expected", pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%t mismatch: %s", $realtime, what);
    endtask

    function automatic range_word_t make_word(dis_status_t st, logic [30:0] lo,
                                              logic [30:0] hi, logic vld, logic lst);
        range_word_t w;
        w.status = st;
        w.range_start = lo;
        w.range_end = hi;
        w.entry_valid = vld;
        w.last_result = lst;
        return w;
    endfunction

    // append one expected word
    task automatic expect_word(input range_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // absorb one value into the predicted table and queue its status word
    task automatic predict_add(input logic [30:0] v);
        int pos;
        int p;
        bit has_prev;
        bit has_next;
        bit joins_left;
        bit joins_right;
        pos = 0;
        while (pos < set_count && set_lo[pos] < v)
            pos++;
        has_prev = pos > 0;
        has_next = pos < set_count;
        p = has_prev ? pos - 1 : 0;
        if (has_prev && set_hi[p] >= v)
        begin
            expect_word(make_word(ST_COVERED, set_lo[p], set_hi[p], 1'b1, 1'b1));
            return;
        end
        if (has_next && set_lo[pos] == v)
        begin
            expect_word(make_word(ST_COVERED, set_lo[pos], set_hi[pos], 1'b1, 1'b1));
            return;
        end
        joins_left = has_prev && ({1'b0, set_hi[p]} + 32'd1 == {1'b0, v});
        joins_right = has_next && ({1'b0, v} + 32'd1 == {1'b0, set_lo[pos]});
        if (joins_left && joins_right)
        begin
            set_hi[p] = set_hi[pos];
            for (int i = pos; i + 1 < set_count; i++)
            begin
                set_lo[i] = set_lo[i + 1];
                set_hi[i] = set_hi[i + 1];
            end
            set_count--;
            expect_word(make_word(ST_JOIN, set_lo[p], set_hi[p], 1'b1, 1'b1));
        end
        else if (joins_left)
        begin
            set_hi[p] = v;
            expect_word(make_word(ST_EXTEND, set_lo[p], v, 1'b1, 1'b1));
        end
        else if (joins_right)
        begin
            set_lo[pos] = v;
            expect_word(make_word(ST_EXTEND, v, set_hi[pos], 1'b1, 1'b1));
        end
        else if (set_count >= TABLE_DEPTH)
            expect_word(make_word(ST_FULL, 31'd0, 31'd0, 1'b0, 1'b1));
        else
        begin
            for (int i = set_count; i > pos; i--)
            begin
                set_lo[i] = set_lo[i - 1];
                set_hi[i] = set_hi[i - 1];
            end
            set_lo[pos] = v;
            set_hi[pos] = v;
            set_count++;
            expect_word(make_word(ST_NEW, v, v, 1'b1, 1'b1));
        end
    endtask

    task automatic predict_list();
        if (set_count == 0)
            expect_word(make_word(ST_LISTED, 31'd0, 31'd0, 1'b0, 1'b1));
        for (int i = 0; i < set_count; i++)
            expect_word(make_word(ST_LISTED, set_lo[i], set_hi[i], 1'b1,
                                  i + 1 == set_count));
    endtask

    // drive one word, with random gaps between bursts
    task automatic send_item(input logic mode, input logic [30:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, v};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (mode == MODE_ADD)
        begin
            predict_add(v);
            adds_sent++;
        end
        else
        begin
            predict_list();
            lists_sent++;
        end
    endtask

    // receiver stall pattern: long open runs alternating with choppy stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_on   <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                rx_stall_on <= ~rx_stall_on;
            m_axis_tready <= rx_stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    // compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        range_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                exp_w = pending_words.pop_front();
                if (m_axis_tdata[2:0] != exp_w.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[2:0], exp_w.status));
                if (m_axis_tdata[33:3] != exp_w.range_start)
                    report_mismatch($sformatf("range_start %0d, expected %0d",
                                              m_axis_tdata[33:3], exp_w.range_start));
                if (m_axis_tdata[64:34] != exp_w.range_end)
                    report_mismatch($sformatf("range_end %0d, expected %0d",
                                              m_axis_tdata[64:34], exp_w.range_end));
                if (m_axis_tdata[65] != exp_w.entry_valid)
                    report_mismatch($sformatf("entry_valid %0b, expected %0b",
                                              m_axis_tdata[65], exp_w.entry_valid));
                if (m_axis_tlast != exp_w.last_result)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_axis_tlast, exp_w.last_result));
            end
        end
    end

    // empty listing, the field extremes and every add outcome short of a full table
    task automatic test_directed();
        send_item(MODE_LIST, VAL_MAX);
        send_item(MODE_ADD, 31'd0);
        send_item(MODE_ADD, 31'd0);
        send_item(MODE_ADD, 31'd1);
        send_item(MODE_ADD, VAL_MAX);
        send_item(MODE_ADD, VAL_MAX - 31'd1);
        send_item(MODE_ADD, 31'd5);
        send_item(MODE_ADD, 31'd3);
        send_item(MODE_ADD, 31'd4);
        send_item(MODE_ADD, 31'd2);
        send_item(MODE_ADD, 31'h5555_5555);
        send_item(MODE_ADD, 31'h2AAA_AAAA);
        send_item(MODE_ADD, 31'h2AAA_AAAB);
        send_item(MODE_ADD, 31'd4);
        send_item(MODE_LIST, 31'd0);
    endtask

    // fill to capacity, then drops, extends and joins on a full table
    task automatic test_full_table();
        for (int i = 0; i < 40; i++)
            send_item(MODE_ADD, 31'd1000 + 31'(i * 3));
        send_item(MODE_LIST, 31'd0);
        send_item(MODE_ADD, 31'd20);
        send_item(MODE_ADD, 31'd1001);
        send_item(MODE_ADD, 31'd1002);
        send_item(MODE_LIST, 31'd0);
    endtask

    // clustered values so extends and joins happen often, some wide noise
    task automatic test_random();
        logic [30:0] base;
        base = 31'($urandom_range(0, 32'h7FFF_FF00));
        for (int i = 0; i < 140; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(MODE_LIST, 31'($urandom));
            else if ($urandom_range(0, 7) == 0)
                send_item(MODE_ADD, 31'($urandom));
            else
                send_item(MODE_ADD, base + 31'($urandom_range(0, 90)));
        end
        send_item(MODE_LIST, 31'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        error_count = 0;
        words_seen = 0;
        adds_sent = 0;
        lists_sent = 0;
        burst_left = 0;
        set_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d adds and %0d listings sent, %0d result words checked",
                 adds_sent, lists_sent, words_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/core/dis_pkg.sv
rtl/core/dis_table.sv
rtl/core/disjoint_interval_set.sv
verif/disjoint_interval_set_test.sv
